// ===== hdl/ppc_pkg.sv =====
// Shared types and constants for the repeated permutation transposition cipher.
// Used by ppc_mod_unit and permutation_power_cipher_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

   localparam int ROUNDS_W = 31;               // width of the rounds register
   localparam int CYC_W    = 9;                // holds a cycle length or size up to 256
   localparam int CNT_W    = $clog2(ROUNDS_W); // bit counter of the modulo unit
   localparam int CSR_W    = 31;               // widest register
   localparam int CSR_IDX_W = 1;

   localparam logic [7:0] PAD_CHAR = 8'h20;
   localparam logic [CYC_W-1:0] SIZE_RESET   = 9'd256;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 31'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS      = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_CHAR  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_MOD,
      ST_APPLY,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                start;
      logic [ROUNDS_W-1:0] dividend;
      logic [CYC_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CYC_W-1:0] rem;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/ppc_mod_unit.sv =====
// Bit-serial restoring modulo unit: rounds modulo cycle length, one bit per cycle.
// Depends on ppc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppc_mod_unit
   import ppc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic [CYC_W-1:0]    rem_ff, rem_in;
   logic [CYC_W-1:0]    divisor_ff, divisor_in;
   logic [ROUNDS_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CYC_W:0]      trial;
   logic [CYC_W:0]      diff;

   always_comb begin
      trial      = {rem_ff, dvd_ff[ROUNDS_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dvd_in     = dvd_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = '0;
         divisor_in = req.divisor;
         dvd_in     = req.dividend;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits CYC_W bits.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[CYC_W-1:0];
         end else begin
            rem_in = trial[CYC_W-1:0];
         end
         dvd_in = {dvd_ff[ROUNDS_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROUNDS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dvd_ff     <= dvd_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("modulo result not below divisor");

   a_no_restart_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.start)
      else $error("modulo unit restarted while busy");

   a_bit_count_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= CNT_W'(ROUNDS_W - 1)))
      else $error("modulo bit counter out of range");

endmodule

`default_nettype wire

// ===== hdl/permutation_power_cipher_top.sv =====
// Top level of the repeated permutation transposition cipher: sequencer,
// permutation table and output buffer. Depends on ppc_pkg and ppc_mod_unit.
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      cmd, index, target, ch
//   rsp_     out        valid / stall      status, out_ch
//   csr_     in         write enable only  index, wdata
//
// Load and read go straight to the response; start first sweeps the buffer.
// A character first walks its cycle in the table, L being its cycle length,
// then finds rounds mod L and steps that far along the cycle: the table walk
// reads one entry per cycle and the modulo unit steps through the 31 bits of
// rounds and then registers the remainder. After reset a sweep fills all MAX_LEN
// buffer entries with spaces; no beat is taken meanwhile. A stalled result sits
// in the output register while the next beat is accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none

module permutation_power_cipher_top
   import ppc_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [7:0]           req_index,
   input  wire logic [7:0]           req_target,
   input  wire logic [7:0]           req_ch,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_status,
   output logic [7:0]                rsp_out_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int AW  = $clog2(MAX_LEN);
   localparam int LIM = (MAX_LEN < 256) ? MAX_LEN : 256;

   logic [7:0] perm_mem [MAX_LEN];
   logic [7:0] buf_mem  [MAX_LEN];

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [CYC_W-1:0]    step_ff, step_in;
   logic [CYC_W-1:0]    cnt_ff, cnt_in;
   logic [7:0]          start_ff, start_in;
   logic [7:0]          ch_ff, ch_in;
   logic                res_status_ff, res_status_in;
   logic                is_read_ff, is_read_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_out_ch_ff, rsp_out_ch_in;
   logic [CYC_W-1:0]    size_in_use_ff, size_in_use_in;
   logic [ROUNDS_W-1:0] rounds_ff, rounds_in;

   logic [7:0]          perm_rdata_ff;
   logic [7:0]          buf_rdata_ff;
   logic [AW-1:0]       perm_raddr;
   logic                perm_we;
   logic                buf_we;
   logic [AW-1:0]       buf_waddr;
   logic [7:0]          buf_wdata;
   logic                buf_re;
   logic                accept;
   logic                idx_in_table;
   logic [CYC_W-1:0]    n_act;
   logic [7:0]          walk_d;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   ppc_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Configuration registers.
   always_comb begin
      size_in_use_in = size_in_use_ff;
      rounds_in      = rounds_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_IN_USE: size_in_use_in = csr_wdata[CYC_W-1:0];
            CSR_ROUNDS:      rounds_in      = csr_wdata[ROUNDS_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      if (size_in_use_ff == '0) begin
         n_act = CYC_W'(1);
      end else if (size_in_use_ff > CYC_W'(LIM)) begin
         n_act = CYC_W'(LIM);
      end else begin
         n_act = size_in_use_ff;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign idx_in_table = (32'(req_index) < MAX_LEN);
   assign walk_d       = perm_rdata_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      ch_in         = ch_ff;
      res_status_in = res_status_ff;
      is_read_in    = is_read_ff;
      rd_ok_in      = rd_ok_ff;
      pend_in       = pend_ff;
      perm_raddr    = AW'(start_ff);
      perm_we       = 1'b0;
      buf_we        = 1'b0;
      buf_waddr     = clr_ff;
      buf_wdata     = PAD_CHAR;
      buf_re        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rounds_ff;
      div_req.divisor  = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_out_ch_in = rsp_out_ch_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            buf_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_LEN - 1)) begin
               state_in = pend_ff ? ST_RESP : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            perm_raddr = AW'(req_index);
            if (accept) begin
               res_status_in = 1'b0;
               is_read_in    = 1'b0;
               start_in      = req_index;
               ch_in         = req_ch;
               unique case (cmd_type'(req_cmd))
                  CMD_LOAD: begin
                     perm_we  = idx_in_table;
                     state_in = ST_RESP;
                  end
                  CMD_START: begin
                     pend_in  = 1'b1;
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_CHAR: begin
                     step_in = CYC_W'(1);
                     if ({1'b0, req_index} >= n_act) begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_READ: begin
                     buf_re     = 1'b1;
                     is_read_in = 1'b1;
                     rd_ok_in   = idx_in_table;
                     state_in   = ST_RESP;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            // walk_d is the entry read for the previous position of the walk.
            priority if ({1'b0, walk_d} >= n_act) begin
               res_status_in = 1'b1;
               state_in      = ST_RESP;
            end else if (walk_d == start_ff) begin
               div_req.start = 1'b1;
               state_in      = ST_MOD;
            end else if (step_ff == n_act) begin
               res_status_in = 1'b1;
               state_in      = ST_RESP;
            end else begin
               perm_raddr = AW'(walk_d);
               step_in    = step_ff + CYC_W'(1);
            end
         end
         ST_MOD: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  buf_we    = 1'b1;
                  buf_waddr = AW'(start_ff);
                  buf_wdata = ch_ff;
                  state_in  = ST_RESP;
               end else begin
                  cnt_in   = div_rsp.rem;
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            if (cnt_ff == CYC_W'(1)) begin
               buf_we    = 1'b1;
               buf_waddr = AW'(walk_d);
               buf_wdata = ch_ff;
               state_in  = ST_RESP;
            end else begin
               perm_raddr = AW'(walk_d);
               cnt_in     = cnt_ff - CYC_W'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_out_ch_in = (is_read_ff && rd_ok_ff) ? buf_rdata_ff : 8'h00;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         size_in_use_ff <= SIZE_RESET;
         rounds_ff      <= ROUNDS_RESET;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         size_in_use_ff <= size_in_use_in;
         rounds_ff      <= rounds_in;
      end
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      start_ff      <= start_in;
      ch_ff         <= ch_in;
      res_status_ff <= res_status_in;
      is_read_ff    <= is_read_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_out_ch_ff <= rsp_out_ch_in;
   end

   // Permutation table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[AW'(req_index)] <= req_target;
      end
      perm_rdata_ff <= perm_mem[perm_raddr];
   end

   // Output buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      if (buf_re) begin
         buf_rdata_ff <= buf_mem[AW'(req_index)];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_ch = rsp_out_ch_ff;

   a_div_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MOD))
      else $error("modulo result outside the modulo state");

   a_walk_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((step_ff != '0) && (step_ff <= n_act)))
      else $error("walk step count out of bounds");

   a_char_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (buf_we && (state_ff != ST_CLEAR)) |-> (32'(buf_waddr) < 32'(n_act)))
      else $error("character placed outside the message");

   a_apply_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> ((cnt_ff != '0) && (cnt_ff < step_ff)))
      else $error("permutation power count out of range");

endmodule

`default_nettype wire
